// ----- hw/rtl/sle_pkg.sv -----
// Shared types and constants for the line and event scanner.
package sle_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned NSlots = 3;

  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_BLANK = 2'd2,
    KIND_EOS   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ES_BLANK = 2'd0,
    ES_BREAK = 2'd1,
    ES_MID   = 2'd2
  } end_state_t;

  typedef enum logic [1:0] {
    LS_START      = 2'd0,
    LS_CONTENT    = 2'd1,
    LS_CR_BLANK   = 2'd2,
    LS_CR_CONTENT = 2'd3
  } line_state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] end_state;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] es;
  } res_t;

  // One request's worth of results, in emission order.
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [NSlots-1:0]      res;
  } entry_t;

  function automatic logic [7:0] bom_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBB;
      default: b = 8'hBF;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/sle_front.sv -----
// Front end: accept requests, track mark and line state, build result entries.
module sle_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sle_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_wr,
  output sle_pkg::entry_t   q_wdata
);

  logic [1:0]           bom_count_r, bom_count_nxt;
  logic                 bom_done_r,  bom_done_nxt;
  sle_pkg::line_state_t ls_r,        ls_nxt;
  logic                 accept;

  assign accept = push && !q_full;

  always_comb begin
    sle_pkg::entry_t e;
    logic [1:0]      n;
    logic [1:0]      pre;
    logic            done;
    logic            scan;
    logic [7:0]      b;
    e             = '0;
    n             = 2'd0;
    pre           = 2'd0;
    scan          = 1'b0;
    b             = in_data.in_byte;
    bom_count_nxt = bom_count_r;
    ls_nxt        = ls_r;
    done          = bom_done_r || (bom_count_r == 2'd3);
    bom_done_nxt  = done;

    if (in_data.cmd) begin
      if (!done) begin
        pre = bom_count_r;
      end
      bom_done_nxt = 1'b1;
    end else if (!done) begin
      if (b == sle_pkg::bom_byte(bom_count_r)) begin
        bom_count_nxt = bom_count_r + 2'd1;
        if (bom_count_r == 2'd2) begin
          bom_done_nxt = 1'b1;
        end
      end else begin
        bom_done_nxt = 1'b1;
        pre          = bom_count_r;
        scan         = 1'b1;
      end
    end else begin
      scan = 1'b1;
    end

    // Release the withheld mark prefix as content.
    if (pre != 2'd0) begin
      e.res[0] = '{kind: sle_pkg::KIND_DATA, data: sle_pkg::bom_byte(2'd0), es: 2'd0};
      n        = 2'd1;
      if (pre == 2'd2) begin
        e.res[1] = '{kind: sle_pkg::KIND_DATA, data: sle_pkg::bom_byte(2'd1), es: 2'd0};
        n        = 2'd2;
      end
      ls_nxt = sle_pkg::LS_CONTENT;
    end

    if (in_data.cmd) begin
      e.res[n].kind = sle_pkg::KIND_EOS;
      e.res[n].data = 8'd0;
      unique case (ls_nxt)
        sle_pkg::LS_CR_BLANK: e.res[n].es = sle_pkg::ES_BLANK;
        sle_pkg::LS_CONTENT:  e.res[n].es = sle_pkg::ES_MID;
        default:              e.res[n].es = sle_pkg::ES_BREAK;
      endcase
      n      = n + 2'd1;
      ls_nxt = sle_pkg::LS_START;
    end else if (scan) begin
      // Complete a held CR line first; an LF right after it is absorbed.
      if (ls_nxt == sle_pkg::LS_CR_BLANK || ls_nxt == sle_pkg::LS_CR_CONTENT) begin
        e.res[n].kind = (ls_nxt == sle_pkg::LS_CR_BLANK) ? sle_pkg::KIND_BLANK
                                                         : sle_pkg::KIND_LINE;
        n      = n + 2'd1;
        ls_nxt = sle_pkg::LS_START;
        if (b == sle_pkg::ChLf) begin
          scan = 1'b0;
        end
      end
      if (scan) begin
        if (b == sle_pkg::ChLf) begin
          e.res[n].kind = (ls_nxt == sle_pkg::LS_START) ? sle_pkg::KIND_BLANK
                                                        : sle_pkg::KIND_LINE;
          n      = n + 2'd1;
          ls_nxt = sle_pkg::LS_START;
        end else if (b == sle_pkg::ChCr) begin
          ls_nxt = (ls_nxt == sle_pkg::LS_START) ? sle_pkg::LS_CR_BLANK
                                                 : sle_pkg::LS_CR_CONTENT;
        end else begin
          e.res[n].kind = sle_pkg::KIND_DATA;
          e.res[n].data = b;
          n      = n + 2'd1;
          ls_nxt = sle_pkg::LS_CONTENT;
        end
      end
    end

    e.cnt   = n;
    q_wdata = e;
    q_wr    = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bom_count_r <= 2'd0;
      bom_done_r  <= 1'b0;
      ls_r        <= sle_pkg::LS_START;
    end else if (accept) begin
      bom_count_r <= bom_count_nxt;
      bom_done_r  <= bom_done_nxt;
      ls_r        <= ls_nxt;
    end
  end

endmodule

// ----- hw/rtl/sle_queue.sv -----
// Short entry queue between front and back ends.
module sle_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  sle_pkg::entry_t wdata,
  input  logic            rd,
  output sle_pkg::entry_t rdata,
  output logic            full,
  output logic            empty
);

  sle_pkg::entry_t                ent_r [sle_pkg::QDepth];
  logic [sle_pkg::QPtrW-1:0]      wp_r, rp_r;
  logic [sle_pkg::QPtrW:0]        cnt_r;

  assign full  = (cnt_r == (sle_pkg::QPtrW+1)'(sle_pkg::QDepth));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      ent_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= rp_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/sle_back.sv -----
// Back end: step through the results of the head entry, one per pop.
module sle_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sle_pkg::entry_t    head,
  input  logic               q_empty,
  input  logic               pop,
  output logic               q_rd,
  output logic               empty,
  output sle_pkg::out_item_t out_data
);

  logic [1:0]    slot_r;
  logic          is_last;
  sle_pkg::res_t cur;

  assign cur     = head.res[slot_r];
  assign is_last = (slot_r == head.cnt - 2'd1);
  assign empty   = q_empty;
  assign q_rd    = pop && !q_empty && is_last;

  assign out_data.kind      = cur.kind;
  assign out_data.out_byte  = cur.data;
  assign out_data.end_state = cur.es;
  assign out_data.last      = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 2'd0;
    end else if (pop && !q_empty) begin
      slot_r <= is_last ? 2'd0 : slot_r + 2'd1;
    end
  end

endmodule

// ----- hw/rtl/sse_line_event_scanner.sv -----
// Top level of the server-sent-event line and event scanner.
// Takes one request per cycle while full is low (a stream byte or an
// end-of-stream flush) and returns content bytes, line ends, blank-line event
// boundaries and an end-of-stream status, oldest first, one result per cycle
// while the consumer pops. A result reaches the output through the queue
// entry written when its request is accepted. Most requests make zero or one
// result; a held CR, a broken byte-order-mark prefix or a flush can make two or
// three, handed out one per pop by the single result path of the back end. A
// four-entry queue between front and back lets input keep flowing through
// such bursts and while the consumer stalls; full rises only when it fills.

module sse_line_event_scanner (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  sle_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output sle_pkg::out_item_t out_data
);

  logic            q_wr;
  logic            q_rd;
  logic            q_empty;
  sle_pkg::entry_t q_wdata;
  sle_pkg::entry_t q_head;

  // Classify each request and update mark/line state at accept.
  sle_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .q_full  (full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  // Hold entries until the back end drains them.
  sle_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_head),
    .full  (full),
    .empty (q_empty)
  );

  // Advance through each entry's results as the consumer pops.
  sle_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .pop      (pop),
    .q_rd     (q_rd),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// ----- tb/sse_line_event_scanner_tb.sv -----
// Self-checking testbench for the server-sent-event line and event scanner.
`timescale 1ns / 100ps

module sse_line_event_scanner_tb;
  import sle_pkg::*;

  localparam logic       CMD_BYTE = 1'b0;
  localparam logic       CMD_EOS  = 1'b1;
  localparam logic [1:0] NO_ES    = 2'd0;
  localparam int         RAND_REQS = 235;
  localparam int         HOLD_CYC  = 60;
  localparam logic [0:2][7:0] MARK = {8'hEF, 8'hBB, 8'hBF};

  // One directed request, with its results typed in where they are obvious.
  typedef struct packed {
    in_item_t             req;
    logic                 typed;
    logic [1:0]           n;
    out_item_t [2:0]      exp;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  // Scanner state mirrored by the predictor.
  logic [1:0]  mark_cnt;
  logic        mark_settled;
  line_state_t line_st;
  out_item_t   burst [0:2];
  int          burst_n;

  out_item_t   due_results [$];
  stim_row_t   dir_rows [$];

  logic calm;         // both sides run without gaps
  logic stall_sink;   // receiver pauses its pops once
  logic last_was_cr;
  int   errors;
  int   n_reqs;
  int   n_eos;
  int   n_results;
  int   full_cycles;

  sse_line_event_scanner u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit far above the slowest correct run.
  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic out_item_t res(kind_t k, logic [7:0] b, logic [1:0] es, logic l);
    out_item_t r;
    r.kind      = k;
    r.out_byte  = b;
    r.end_state = es;
    r.last      = l;
    return r;
  endfunction

  function automatic void emit(kind_t k, logic [7:0] b, logic [1:0] es);
    burst[burst_n] = res(k, b, es, 1'b0);
    burst_n++;
  endfunction

  // Release withheld mark bytes as content; the line then holds content.
  function automatic void release_mark_prefix();
    int cnt;
    int k;
    cnt = (mark_cnt > 2'd2) ? 2 : int'(mark_cnt);
    for (k = 0; k < cnt; k++) emit(KIND_DATA, MARK[k], NO_ES);
    if (cnt > 0) line_st = LS_CONTENT;
  endfunction

  // Work out the results of one request into burst[], and advance the state.
  function automatic void scan_predict(input in_item_t req);
    logic [1:0] es;
    logic [7:0] b;
    b = req.in_byte;
    burst_n = 0;
    if (!mark_settled && mark_cnt == 2'd3) mark_settled = 1'b1;
    if (req.cmd == CMD_EOS) begin
      if (!mark_settled) release_mark_prefix();
      mark_settled = 1'b1;
      if (line_st == LS_CR_BLANK) es = ES_BLANK;
      else if (line_st == LS_CONTENT) es = ES_MID;
      else es = ES_BREAK;
      emit(KIND_EOS, 8'h00, es);
      line_st = LS_START;
    end else begin
      if (!mark_settled) begin
        if (b == MARK[mark_cnt]) begin
          // Swallow a matching mark byte; nothing comes out yet.
          mark_cnt++;
          if (mark_cnt == 2'd3) mark_settled = 1'b1;
          return;
        end
        mark_settled = 1'b1;
        release_mark_prefix();
      end
      // Complete a held CR first; an LF right after it is its other half.
      if (line_st == LS_CR_BLANK || line_st == LS_CR_CONTENT) begin
        emit((line_st == LS_CR_BLANK) ? KIND_BLANK : KIND_LINE, 8'h00, NO_ES);
        line_st = LS_START;
        if (b == ChLf) begin
          burst[burst_n - 1].last = 1'b1;
          return;
        end
      end
      if (b == ChLf) begin
        emit((line_st == LS_START) ? KIND_BLANK : KIND_LINE, 8'h00, NO_ES);
        line_st = LS_START;
      end else if (b == ChCr) begin
        line_st = (line_st == LS_START) ? LS_CR_BLANK : LS_CR_CONTENT;
      end else begin
        emit(KIND_DATA, b, NO_ES);
        line_st = LS_CONTENT;
      end
    end
    if (burst_n > 0) burst[burst_n - 1].last = 1'b1;
  endfunction

  task automatic add_row(input logic cmd, input logic [7:0] b, input logic typed,
                         input logic [1:0] n, input out_item_t e0, input out_item_t e1,
                         input out_item_t e2);
    stim_row_t row;
    row.req.cmd     = cmd;
    row.req.in_byte = b;
    row.typed       = typed;
    row.n           = n;
    row.exp[0]      = e0;
    row.exp[1]      = e1;
    row.exp[2]      = e2;
    dir_rows.push_back(row);
  endtask

  // Mostly well-formed lines: printable content, LF / CR / CRLF endings,
  // the odd raw byte and an occasional end of stream.
  function automatic in_item_t gen_request();
    in_item_t r;
    int       pick;
    pick      = $urandom_range(99);
    r.cmd     = CMD_BYTE;
    r.in_byte = 8'($urandom_range(255));
    if (last_was_cr && pick < 50) r.in_byte = ChLf;
    else if (pick < 3) r.cmd = CMD_EOS;
    else if (pick < 55) r.in_byte = 8'($urandom_range(8'h7E, 8'h20));
    else if (pick < 68) r.in_byte = ChLf;
    else if (pick < 81) r.in_byte = ChCr;
    last_was_cr = (r.cmd == CMD_BYTE && r.in_byte == ChCr);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Offer one request: idle at random, hold it until accepted, then queue
  // its results. Call and return at a falling edge.
  task automatic offer(input stim_row_t row);
    int k;
    while (!calm && $urandom_range(99) < 38) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= row.req;
    @(posedge clk);
    while (full) @(posedge clk);
    scan_predict(row.req);
    if (row.typed) begin
      for (k = 0; k < row.n; k++) due_results.push_back(row.exp[k]);
    end else begin
      for (k = 0; k < burst_n; k++) due_results.push_back(burst[k]);
    end
    n_reqs++;
    if (row.req.cmd == CMD_EOS) n_eos++;
    @(negedge clk);
  endtask

  // Receiver: pop at random, run gap-free while calm, and hold off for a
  // long stretch on request so the internal queue fills and full rises.
  initial begin : sink
    int held;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_sink) begin
        pop <= 1'b0;
        for (held = 1; held < HOLD_CYC; held++) @(negedge clk);
        stall_sink = 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  // Compare every popped result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && full) full_cycles++;
    if (rst_n && pop && !empty) begin
      n_results++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, kind", out_data.kind, 0);
      end else begin
        want = due_results.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch("kind", out_data.kind, want.kind);
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_data.out_byte, want.out_byte);
        if (out_data.end_state !== want.end_state)
          report_mismatch("end_state", out_data.end_state, want.end_state);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        i;
    rst_n        = 1'b0;
    push         = 1'b0;
    in_data      = '0;
    calm         = 1'b0;
    stall_sink   = 1'b0;
    last_was_cr  = 1'b0;
    errors       = 0;
    n_reqs       = 0;
    n_eos        = 0;
    n_results    = 0;
    full_cycles  = 0;
    mark_cnt     = 2'd0;
    mark_settled = 1'b0;
    line_st      = LS_START;

    // Partial mark flushed by end of stream: both withheld bytes come back.
    add_row(CMD_BYTE, 8'hEF, 1'b1, 2'd0, '0, '0, '0);
    add_row(CMD_BYTE, 8'hBB, 1'b1, 2'd0, '0, '0, '0);
    add_row(CMD_EOS, 8'hFF, 1'b1, 2'd3, res(KIND_DATA, 8'hEF, NO_ES, 1'b0),
            res(KIND_DATA, 8'hBB, NO_ES, 1'b0), res(KIND_EOS, 8'h00, ES_MID, 1'b1));
    // Bare LF on an empty line, byte extremes, end mid line.
    add_row(CMD_BYTE, ChLf, 1'b1, 2'd1, res(KIND_BLANK, 8'h00, NO_ES, 1'b1), '0, '0);
    add_row(CMD_BYTE, 8'h00, 1'b1, 2'd1, res(KIND_DATA, 8'h00, NO_ES, 1'b1), '0, '0);
    add_row(CMD_BYTE, 8'hFF, 1'b1, 2'd1, res(KIND_DATA, 8'hFF, NO_ES, 1'b1), '0, '0);
    add_row(CMD_EOS, 8'h00, 1'b1, 2'd1, res(KIND_EOS, 8'h00, ES_MID, 1'b1), '0, '0);
    // CRLF on a blank line: one boundary only.
    add_row(CMD_BYTE, ChCr, 1'b1, 2'd0, '0, '0, '0);
    add_row(CMD_BYTE, ChLf, 1'b1, 2'd1, res(KIND_BLANK, 8'h00, NO_ES, 1'b1), '0, '0);
    // Content then CR CR: line end, then a held blank CR broken by content.
    add_row(CMD_BYTE, 8'h41, 1'b1, 2'd1, res(KIND_DATA, 8'h41, NO_ES, 1'b1), '0, '0);
    add_row(CMD_BYTE, ChCr, 1'b1, 2'd0, '0, '0, '0);
    add_row(CMD_BYTE, ChCr, 1'b1, 2'd1, res(KIND_LINE, 8'h00, NO_ES, 1'b1), '0, '0);
    add_row(CMD_BYTE, 8'h42, 1'b1, 2'd2, res(KIND_BLANK, 8'h00, NO_ES, 1'b0),
            res(KIND_DATA, 8'h42, NO_ES, 1'b1), '0);
    // End of stream with a CR pending after content, on a blank line, at start.
    add_row(CMD_BYTE, ChCr, 1'b1, 2'd0, '0, '0, '0);
    add_row(CMD_EOS, 8'h5A, 1'b1, 2'd1, res(KIND_EOS, 8'h00, ES_BREAK, 1'b1), '0, '0);
    add_row(CMD_BYTE, ChCr, 1'b1, 2'd0, '0, '0, '0);
    add_row(CMD_EOS, 8'hFF, 1'b1, 2'd1, res(KIND_EOS, 8'h00, ES_BLANK, 1'b1), '0, '0);
    add_row(CMD_EOS, 8'h00, 1'b1, 2'd1, res(KIND_EOS, 8'h00, ES_BREAK, 1'b1), '0, '0);
    // Two blank CRs in a row.
    add_row(CMD_BYTE, ChCr, 1'b1, 2'd0, '0, '0, '0);
    add_row(CMD_BYTE, ChCr, 1'b1, 2'd1, res(KIND_BLANK, 8'h00, NO_ES, 1'b1), '0, '0);
    // A full mark once the question is settled passes as plain content.
    add_row(CMD_BYTE, 8'hEF, 1'b0, 2'd0, '0, '0, '0);
    add_row(CMD_BYTE, 8'hBB, 1'b0, 2'd0, '0, '0, '0);
    add_row(CMD_BYTE, 8'hBF, 1'b0, 2'd0, '0, '0, '0);
    add_row(CMD_BYTE, 8'h55, 1'b0, 2'd0, '0, '0, '0);
    add_row(CMD_BYTE, ChLf, 1'b1, 2'd1, res(KIND_LINE, 8'h00, NO_ES, 1'b1), '0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) offer(dir_rows[i]);

    row.typed = 1'b0;
    row.n     = 2'd0;
    row.exp   = '0;
    for (i = 0; i < RAND_REQS; i++) begin
      if (i == 70) begin
        // Pause the sender until every queued result has drained.
        push <= 1'b0;
        wait (due_results.size() == 0);
        @(negedge clk);
        calm = 1'b1;
      end
      if (i == 130) calm = 1'b0;
      if (i == 150) stall_sink = 1'b1;
      row.req = gen_request();
      offer(row);
    end
    push <= 1'b0;

    // Drain, then give stray results a chance to show up.
    wait (due_results.size() == 0);
    repeat (20) @(posedge clk);

    $display("Run covered %0d requests (%0d end of stream) and %0d results checked.",
             n_reqs, n_eos, n_results);
    $display("Input held off by full for %0d cycles.", full_cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
